>>> rtl/core/ultrasonic_obstacle_escape_fsm_core_macros.svh
// Assertion helpers used by the control module.
// Both macros expand to nothing when SYNTHESIS is defined.
`ifndef ULTRASONIC_OBSTACLE_ESCAPE_FSM_CORE_MACROS_SVH
`define ULTRASONIC_OBSTACLE_ESCAPE_FSM_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define UOE_ASSERT_HOLDS(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication
`define UOE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define UOE_ASSERT_HOLDS(lbl, clk, rstn, ante, cons)
`define UOE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/uoe_pkg.sv
package uoe_pkg;

  // Default move time in milliseconds ticks
  localparam int unsigned MOVE_MS_DEF = 250;

  // Echo time to 1/16 cm: (echo * DIST_MUL) >> 16
  localparam int unsigned DIST_W   = 15;
  localparam int unsigned ECHO_W   = 16;
  localparam int unsigned PROD_W   = ECHO_W + DIST_W;
  localparam logic [DIST_W-1:0] DIST_MUL = 15'd17826;

  // Opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_CMD    = 2'd2;

  // Drive commands
  localparam logic [15:0] CMD_FWD   = 16'd1;
  localparam logic [15:0] CMD_RIGHT = 16'd2;
  localparam logic [15:0] CMD_LEFT  = 16'd3;

  // Bridge direction codes
  localparam logic [1:0] DIR_FWD     = 2'd2;
  localparam logic [1:0] DIR_REV     = 2'd1;
  localparam logic [1:0] STEER_RIGHT = 2'd2;
  localparam logic [1:0] STEER_LEFT  = 2'd1;

  // Buzzer codes
  localparam logic [1:0] TONE_OFF  = 2'd0;
  localparam logic [1:0] TONE_LOW  = 2'd1;
  localparam logic [1:0] TONE_HIGH = 2'd2;

  // Full duty used for the drive motor while turning
  localparam logic [7:0] DUTY_FULL = 8'd255;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_PWM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_PWM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_CM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIND_CM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_CM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_MS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MS  = 3'd7;

  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] front_echo_us;
    logic [15:0] left_echo_us;
    logic [15:0] right_echo_us;
    logic [15:0] drive_command;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive_enable;
    logic [1:0] drive_dir;
    logic [7:0] steer_enable;
    logic [1:0] steer_dir;
    logic [1:0] buzzer_tone;
    logic       measure_request;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  drive_pwm;
    logic [7:0]  steer_pwm;
    logic [9:0]  near_cm;
    logic [9:0]  blind_cm;
    logic [9:0]  jump_cm;
    logic [9:0]  range_cm;
    logic [15:0] beep_ms;
    logic [15:0] pause_ms;
  } cfg_t;

  // Item after distance conversion
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] drive_command;
    dist_t       front_d;
    dist_t       left_d;
    dist_t       right_d;
  } conv_t;

  typedef struct packed {
    logic [7:0] drive_enable;
    logic [1:0] drive_dir;
    logic [7:0] steer_enable;
    logic [1:0] steer_dir;
  } motor_t;

endpackage

>>> rtl/core/uoe_in_if.sv
interface uoe_in_if;
  import uoe_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/uoe_out_if.sv
interface uoe_out_if;
  import uoe_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ultrasonic_obstacle_escape_fsm_core.sv
// Pipeline: a transaction is registered in the conversion stage, then in the
// control stage's result register; output back-pressure stalls both stages.
// Throughput: one transaction per cycle without output stalls; set by the control
// stage state update, which filters distances and steps the sequencer together.
// Reset (rst_ni low, asynchronous): registers return to their defaults, sequencer
// idle, distances zero, motors stopped, both pipeline stages empty.
module ultrasonic_obstacle_escape_fsm_core #(
  parameter int unsigned MOVE_MS = uoe_pkg::MOVE_MS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uoe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uoe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  uoe_in_if.sink                         item_i,
  uoe_out_if.source                      res_o
);
  import uoe_pkg::*;

  cfg_t  cfg;
  conv_t conv_data;
  logic  conv_valid;
  logic  conv_ready;

  uoe_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  uoe_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(item_i.valid),
    .ready_o(item_i.ready),
    .item_i (item_i.data),
    .valid_o(conv_valid),
    .ready_i(conv_ready),
    .data_o (conv_data)
  );

  uoe_ctrl #(
    .MOVE_MS(MOVE_MS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .valid_i(conv_valid),
    .ready_o(conv_ready),
    .data_i (conv_data),
    .valid_o(res_o.valid),
    .ready_i(res_o.ready),
    .data_o (res_o.data)
  );
endmodule

>>> rtl/core/uoe_cfg.sv
module uoe_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [uoe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [uoe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output uoe_pkg::cfg_t                    cfg_o
);
  import uoe_pkg::*;

  cfg_t cfg_q;

  // Write one register per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_pwm <= 8'd255;
      cfg_q.steer_pwm <= 8'd255;
      cfg_q.near_cm   <= 10'd30;
      cfg_q.blind_cm  <= 10'd5;
      cfg_q.jump_cm   <= 10'd100;
      cfg_q.range_cm  <= 10'd600;
      cfg_q.beep_ms   <= 16'd1000;
      cfg_q.pause_ms  <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DRIVE_PWM: cfg_q.drive_pwm <= cfg_data_i[7:0];
        CFG_STEER_PWM: cfg_q.steer_pwm <= cfg_data_i[7:0];
        CFG_NEAR_CM:   cfg_q.near_cm   <= cfg_data_i[9:0];
        CFG_BLIND_CM:  cfg_q.blind_cm  <= cfg_data_i[9:0];
        CFG_JUMP_CM:   cfg_q.jump_cm   <= cfg_data_i[9:0];
        CFG_RANGE_CM:  cfg_q.range_cm  <= cfg_data_i[9:0];
        CFG_BEEP_MS:   cfg_q.beep_ms   <= cfg_data_i;
        CFG_PAUSE_MS:  cfg_q.pause_ms  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

>>> rtl/core/uoe_conv.sv
module uoe_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  uoe_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output uoe_pkg::conv_t    data_o
);
  import uoe_pkg::*;

  logic  valid_q, valid_d;
  conv_t data_q, data_d;
  logic  accept;

  // Echo time to distance in 1/16 cm
  function automatic dist_t echo_to_dist(input logic [ECHO_W-1:0] echo);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(echo) * PROD_W'(DIST_MUL);
    return prod[PROD_W-1:ECHO_W];
  endfunction

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // Convert all three sensors on the way into the stage register
  always_comb begin
    data_d.opcode        = item_i.opcode;
    data_d.drive_command = item_i.drive_command;
    data_d.front_d       = echo_to_dist(item_i.front_echo_us);
    data_d.left_d        = echo_to_dist(item_i.left_echo_us);
    data_d.right_d       = echo_to_dist(item_i.right_echo_us);
    if (accept) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on accept only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

>>> rtl/core/uoe_filter.sv
module uoe_filter (
  input  uoe_pkg::dist_t d_i,
  input  uoe_pkg::dist_t last_i,
  input  logic [9:0]     jump_cm_i,
  input  logic [9:0]     range_cm_i,
  output uoe_pkg::dist_t dist_o
);
  import uoe_pkg::*;

  dist_t diff;
  dist_t jump_lim;
  dist_t range_lim;
  logic  reject;

  // Drop a reading that jumps too far or reaches the range limit
  always_comb begin
    diff      = (d_i > last_i) ? (d_i - last_i) : (last_i - d_i);
    jump_lim  = {1'b0, jump_cm_i, 4'b0000};
    range_lim = {1'b0, range_cm_i, 4'b0000};
    reject    = (diff >= jump_lim) || (d_i >= range_lim);
    dist_o    = reject ? last_i : d_i;
  end
endmodule

>>> rtl/core/uoe_ctrl.sv
`include "ultrasonic_obstacle_escape_fsm_core_macros.svh"

module uoe_ctrl #(
  parameter int unsigned MOVE_MS = uoe_pkg::MOVE_MS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uoe_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  uoe_pkg::conv_t     data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output uoe_pkg::out_item_t data_o
);
  import uoe_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BEEP,
    PH_MOVE,
    PH_AWAIT,
    PH_PAUSE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        side_q, side_d;
  logic [15:0] timer_q, timer_d;
  dist_t       front_q, front_d;
  dist_t       left_q, left_d;
  dist_t       right_q, right_d;
  motor_t      motor_q, motor_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  dist_t front_f, left_f, right_f;
  dist_t fd, ld, rd;
  dist_t near_lim;
  logic  take;
  logic  is_sample;
  logic  tick;
  logic  clear;
  logic  band_now;

  function automatic logic in_band(input dist_t d, input cfg_t c);
    return (d > {1'b0, c.blind_cm, 4'b0000}) && (d < {1'b0, c.near_cm, 4'b0000});
  endfunction

  uoe_filter u_filt_front (
    .d_i       (data_i.front_d),
    .last_i    (front_q),
    .jump_cm_i (cfg_i.jump_cm),
    .range_cm_i(cfg_i.range_cm),
    .dist_o    (front_f)
  );

  uoe_filter u_filt_left (
    .d_i       (data_i.left_d),
    .last_i    (left_q),
    .jump_cm_i (cfg_i.jump_cm),
    .range_cm_i(cfg_i.range_cm),
    .dist_o    (left_f)
  );

  uoe_filter u_filt_right (
    .d_i       (data_i.right_d),
    .last_i    (right_q),
    .jump_cm_i (cfg_i.jump_cm),
    .range_cm_i(cfg_i.range_cm),
    .dist_o    (right_f)
  );

  assign ready_o  = !out_valid_q || ready_i;
  assign take     = valid_i && ready_o;
  assign near_lim = {1'b0, cfg_i.near_cm, 4'b0000};

  // Advance the escape sequence by one transaction
  always_comb begin
    phase_d = phase_q;
    side_d  = side_q;
    timer_d = timer_q;
    motor_d = motor_q;

    is_sample = (data_i.opcode == OP_SAMPLE) &&
                ((phase_q == PH_IDLE) || (phase_q == PH_AWAIT));
    tick      = (data_i.opcode == OP_TICK);
    fd = is_sample ? front_f : front_q;
    ld = is_sample ? left_f  : left_q;
    rd = is_sample ? right_f : right_q;
    front_d = take ? fd : front_q;
    left_d  = take ? ld : left_q;
    right_d = take ? rd : right_q;

    clear    = side_q ? ((ld >= near_lim) || (rd >= near_lim)) : (fd >= near_lim);
    band_now = side_q ? (in_band(ld, cfg_i) || in_band(rd, cfg_i)) : in_band(fd, cfg_i);

    if (take) begin
      case (phase_q)
        PH_IDLE: begin
          if (is_sample) begin
            if (in_band(ld, cfg_i) || in_band(rd, cfg_i)) begin
              side_d               = 1'b1;
              motor_d.drive_enable = 8'd0;
              motor_d.steer_enable = 8'd0;
              phase_d              = PH_BEEP;
              timer_d              = cfg_i.beep_ms;
            end else if (in_band(fd, cfg_i)) begin
              side_d               = 1'b0;
              motor_d.drive_enable = 8'd0;
              motor_d.steer_enable = 8'd0;
              phase_d              = PH_BEEP;
              timer_d              = cfg_i.beep_ms;
            end
          end else if (data_i.opcode == OP_CMD) begin
            case (data_i.drive_command)
              CMD_FWD: begin
                motor_d.drive_enable = cfg_i.drive_pwm;
                motor_d.drive_dir    = DIR_FWD;
              end
              CMD_RIGHT: begin
                motor_d = '{DUTY_FULL, DIR_FWD, cfg_i.steer_pwm, STEER_RIGHT};
              end
              CMD_LEFT: begin
                motor_d = '{DUTY_FULL, DIR_FWD, cfg_i.steer_pwm, STEER_LEFT};
              end
              default: begin
                motor_d.drive_enable = 8'd0;
                motor_d.steer_enable = 8'd0;
              end
            endcase
          end
        end
        PH_AWAIT: begin
          if (is_sample) begin
            if (clear) begin
              phase_d = PH_IDLE;
            end else begin
              motor_d.drive_enable = 8'd0;
              motor_d.steer_enable = 8'd0;
              phase_d              = PH_PAUSE;
              timer_d              = cfg_i.pause_ms;
            end
          end
        end
        PH_BEEP: begin
          if (tick) begin
            if (timer_q > 16'd1) begin
              timer_d = timer_q - 16'd1;
            end else begin
              motor_d.drive_enable = cfg_i.drive_pwm;
              motor_d.drive_dir    = side_q ? DIR_REV : DIR_FWD;
              phase_d              = PH_MOVE;
              timer_d              = 16'(MOVE_MS);
            end
          end
        end
        PH_MOVE: begin
          if (tick) begin
            if (timer_q > 16'd1) begin
              timer_d = timer_q - 16'd1;
            end else begin
              phase_d = PH_AWAIT;
              timer_d = 16'd0;
            end
          end
        end
        PH_PAUSE: begin
          if (tick) begin
            if (timer_q > 16'd1) begin
              timer_d = timer_q - 16'd1;
            end else if (band_now) begin
              motor_d.drive_enable = 8'd0;
              motor_d.steer_enable = 8'd0;
              phase_d              = PH_BEEP;
              timer_d              = cfg_i.beep_ms;
            end else begin
              phase_d = PH_IDLE;
              timer_d = 16'd0;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    // Result reflects the state after the transaction
    out_d.drive_enable    = motor_d.drive_enable;
    out_d.drive_dir       = motor_d.drive_dir;
    out_d.steer_enable    = motor_d.steer_enable;
    out_d.steer_dir       = motor_d.steer_dir;
    out_d.buzzer_tone     = (phase_d == PH_BEEP) ? (side_d ? TONE_HIGH : TONE_LOW) : TONE_OFF;
    out_d.measure_request = (phase_d == PH_AWAIT);
    out_d.busy_res        = (phase_d != PH_IDLE);

    if (take) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      side_q      <= 1'b0;
      timer_q     <= 16'd0;
      front_q     <= '0;
      left_q      <= '0;
      right_q     <= '0;
      motor_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      side_q      <= side_d;
      timer_q     <= timer_d;
      front_q     <= front_d;
      left_q      <= left_d;
      right_q     <= right_d;
      motor_q     <= motor_d;
      out_valid_q <= out_valid_d;
      if (take) begin
        out_q <= out_d;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  `UOE_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, take, out_valid_q)
  `UOE_ASSERT_NEXT(a_cmd_ignored_busy, clk_i, rst_ni, take && (data_i.opcode == OP_CMD) && (phase_q != PH_IDLE), $stable(motor_q))
  `UOE_ASSERT_NEXT(a_tick_ignored_idle, clk_i, rst_ni, take && (data_i.opcode == OP_TICK) && (phase_q == PH_IDLE), (phase_q == PH_IDLE) && $stable(motor_q))
  `UOE_ASSERT_HOLDS(a_stopped_beep_pause, clk_i, rst_ni, (phase_q == PH_BEEP) || (phase_q == PH_PAUSE), (motor_q.drive_enable == 8'd0) && (motor_q.steer_enable == 8'd0))
endmodule
